// ===== rtl/png_unf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// png_unf_pkg
// Shared codes and types for the PNG scanline unfilter.
// ----------------------------------------------------------------------------
package png_unf_pkg;

  // filter type codes, as carried in the first byte of each scanline
  localparam logic [2:0] FILT_NONE    = 3'd0;
  localparam logic [2:0] FILT_SUB     = 3'd1;
  localparam logic [2:0] FILT_UP      = 3'd2;
  localparam logic [2:0] FILT_AVERAGE = 3'd3;
  localparam logic [2:0] FILT_PAETH   = 3'd4;

  // configuration register indexes
  localparam logic [3:0] REG_BYTES_PER_PIXEL = 4'd0;
  localparam logic [3:0] REG_ROW_BYTES       = 4'd1;

  // control carried with a beat from the input register to the compute stage
  typedef struct packed {
    logic       bad;        // error result, no pixel work
    logic       last;       // last byte of the scanline
    logic       b_zero;     // first row of an image: above reads zero
    logic       row_start;  // first data byte of the row: history reads zero
    logic [2:0] filter;
  } stage_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/png_scanline_unfilter_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// png_scanline_unfilter_core
// PNG filter reconstruction (None/Sub/Up/Average/Paeth) over a byte stream,
// with the previous scanline held in a row store.
// ----------------------------------------------------------------------------
//
//  channel  dir  beat fields (tdata / tuser / tlast)
//  -------  ---  -------------------------------------------------------------
//  s_*      in   tdata[7:0] byte_value, tuser[0] start_of_image
//  m_*      out  tdata[7:0] pixel_byte, tlast end_of_row, tuser[0] bad_filter
//  cfg_*    in   cfg_index selects register, cfg_data is the value; ready out of reset
//
//  One input beat per cycle, sustained while m_tready stays high. An accepted
//  data byte is registered in the compute stage, and its result then in the
//  output register, which drives m_tvalid.
//  Filter-type bytes and bytes dropped after a bad filter produce no output beat.
//  The row store is a RAM with one read and one write per cycle; it needs no
//  clearing pass, since the first row of each image reads zeros above.
//  Reset (rst, synchronous) clears control state and sets both config registers
//  to one; s_tready and cfg_ready are low while rst is high.
//  A stall on m_tready holds the output register and the compute stage, and
//  s_tready drops only when both are full.
//
module png_scanline_unfilter_core #(
  parameter int MAX_ROW_BYTES   = 16384,
  parameter int MAX_PIXEL_BYTES = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,

  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] byte_value
  input  wire logic [0:0]  s_tuser,   // [0] start_of_image

  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [7:0]  m_tdata,   // [7:0] pixel_byte
  output      logic        m_tlast,   // end_of_row
  output      logic [0:0]  m_tuser,   // [0] bad_filter

  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [3:0]  cfg_index,
  input  wire logic [14:0] cfg_data
);

  localparam int POS_W = $clog2(MAX_ROW_BYTES);
  localparam int CMP_W = (POS_W + 1 > 15) ? POS_W + 1 : 15;
  localparam int SEL_W = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

  // -------------------------------------------------------------------------
  // configuration
  // -------------------------------------------------------------------------
  logic [3:0]  bytes_per_pixel;
  logic [14:0] row_bytes;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_per_pixel <= 4'd1;
      row_bytes       <= 15'd1;
    end else if (cfg_valid) begin
      if (cfg_index == png_unf_pkg::REG_BYTES_PER_PIXEL) begin
        bytes_per_pixel <= cfg_data[3:0];
      end else if (cfg_index == png_unf_pkg::REG_ROW_BYTES) begin
        row_bytes <= cfg_data;
      end
    end
  end

  // clamped settings: zero acts as one, too large saturates
  logic [CMP_W-1:0] rb_eff;
  logic [SEL_W-1:0] bpp_sel;

  always_comb begin
    if (row_bytes == 15'd0) begin
      rb_eff = CMP_W'(1);
    end else if (CMP_W'(row_bytes) > CMP_W'(MAX_ROW_BYTES)) begin
      rb_eff = CMP_W'(MAX_ROW_BYTES);
    end else begin
      rb_eff = CMP_W'(row_bytes);
    end
    if (bytes_per_pixel == 4'd0) begin
      bpp_sel = '0;
    end else if (bytes_per_pixel > 4'(MAX_PIXEL_BYTES)) begin
      bpp_sel = SEL_W'(MAX_PIXEL_BYTES - 1);
    end else begin
      bpp_sel = SEL_W'(bytes_per_pixel - 4'd1);
    end
  end

  // -------------------------------------------------------------------------
  // input side: scanline control, decided at accept
  // -------------------------------------------------------------------------
  logic             in_fire;
  logic             soi;
  logic             awaiting, awaiting_next;
  logic             first_row, first_row_next;
  logic             halted, halted_next;
  logic [POS_W-1:0] pos, pos_next;
  logic [2:0]       act_filter, act_filter_next;

  logic             aw_now, fr_now, h_now;
  logic [POS_W-1:0] p_now;
  logic             last_now;

  logic                    s1_load;
  png_unf_pkg::stage_ctl_t ld_ctl;
  logic                    s1_go;

  assign in_fire = s_tvalid && s_tready;
  assign soi     = s_tuser[0];

  // start of image restarts the row and the image before anything else
  assign aw_now   = soi ? 1'b1 : awaiting;
  assign fr_now   = soi ? 1'b1 : first_row;
  assign h_now    = soi ? 1'b0 : halted;
  assign p_now    = soi ? '0 : pos;
  assign last_now = (CMP_W'(p_now) + CMP_W'(1)) >= rb_eff;

  always_comb begin
    awaiting_next   = awaiting;
    first_row_next  = first_row;
    halted_next     = halted;
    pos_next        = pos;
    act_filter_next = act_filter;
    s1_load         = 1'b0;
    ld_ctl          = '0;
    if (in_fire) begin
      awaiting_next  = aw_now;
      first_row_next = fr_now;
      halted_next    = h_now;
      pos_next       = p_now;
      if (!h_now) begin
        if (aw_now) begin
          if (s_tdata > 8'(png_unf_pkg::FILT_PAETH)) begin
            halted_next = 1'b1;
            s1_load     = 1'b1;
            ld_ctl.bad  = 1'b1;
          end else begin
            act_filter_next = s_tdata[2:0];
            awaiting_next   = 1'b0;
            pos_next        = '0;
          end
        end else begin
          s1_load          = 1'b1;
          ld_ctl.last      = last_now;
          ld_ctl.b_zero    = fr_now;
          ld_ctl.row_start = (p_now == '0);
          ld_ctl.filter    = act_filter;
          if (last_now) begin
            awaiting_next  = 1'b1;
            first_row_next = 1'b0;
            pos_next       = '0;
          end else begin
            pos_next = p_now + POS_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      awaiting   <= 1'b1;
      first_row  <= 1'b1;
      halted     <= 1'b0;
      pos        <= '0;
      act_filter <= png_unf_pkg::FILT_NONE;
    end else begin
      awaiting   <= awaiting_next;
      first_row  <= first_row_next;
      halted     <= halted_next;
      pos        <= pos_next;
      act_filter <= act_filter_next;
    end
  end

  // -------------------------------------------------------------------------
  // compute stage: input register plus row-store read data
  // -------------------------------------------------------------------------
  logic                    s1_valid;
  png_unf_pkg::stage_ctl_t s1_ctl;
  logic [7:0]              s1_x;
  logic [POS_W-1:0]        s1_pos;
  logic [SEL_W-1:0]        s1_sel;

  logic                    o_valid;

  assign s1_go    = s1_valid && (!o_valid || m_tready);
  assign s_tready = !rst && (!s1_valid || s1_go);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_ctl <= ld_ctl;
      s1_x   <= s_tdata;
      s1_pos <= p_now;
      s1_sel <= bpp_sel;
    end
  end

  // row store: read at accept, written when the byte leaves the stage.
  // A position is rewritten by the same byte that read it, after the read.
  logic [7:0] above_rd;
  logic       row_we;
  logic [7:0] val;

  assign row_we = s1_go && !s1_ctl.bad;

  png_unf_ram #(
    .WIDTH (8),
    .DEPTH (MAX_ROW_BYTES)
  ) u_row_store (
    .clk   (clk),
    .we    (row_we),
    .waddr (s1_pos),
    .wdata (val),
    .re    (s1_load),
    .raddr (p_now),
    .rdata (above_rd)
  );

  // last MAX_PIXEL_BYTES reconstructed and above bytes; entry 0 is newest
  logic [7:0] left_hist  [MAX_PIXEL_BYTES];
  logic [7:0] above_hist [MAX_PIXEL_BYTES];
  logic [7:0] nb_a, nb_b, nb_c, pred;

  assign nb_a = s1_ctl.row_start ? 8'd0 : left_hist[s1_sel];
  assign nb_c = s1_ctl.row_start ? 8'd0 : above_hist[s1_sel];
  assign nb_b = s1_ctl.b_zero ? 8'd0 : above_rd;

  png_unf_predict u_predict (
    .filter (s1_ctl.filter),
    .a      (nb_a),
    .b      (nb_b),
    .c      (nb_c),
    .pred   (pred)
  );

  assign val = s1_x + pred;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
        left_hist[i]  <= 8'd0;
        above_hist[i] <= 8'd0;
      end
    end else if (row_we) begin
      left_hist[0]  <= val;
      above_hist[0] <= nb_b;
      for (int i = 1; i < MAX_PIXEL_BYTES; i++) begin
        left_hist[i]  <= s1_ctl.row_start ? 8'd0 : left_hist[i-1];
        above_hist[i] <= s1_ctl.row_start ? 8'd0 : above_hist[i-1];
      end
    end
  end

  // -------------------------------------------------------------------------
  // output register
  // -------------------------------------------------------------------------
  logic [7:0] o_byte;
  logic       o_last;
  logic       o_bad;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (s1_go) begin
      o_valid <= 1'b1;
    end else if (m_tready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      o_byte <= s1_ctl.bad ? 8'd0 : val;
      o_last <= s1_ctl.bad ? 1'b0 : s1_ctl.last;
      o_bad  <= s1_ctl.bad;
    end
  end

  assign m_tvalid   = o_valid;
  assign m_tdata    = o_byte;
  assign m_tlast    = o_last;
  assign m_tuser[0] = o_bad;

  // -------------------------------------------------------------------------
  // assertions
  // -------------------------------------------------------------------------
  // error beat carries no pixel and no row end
  a_err_beat: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata == 8'd0 && !m_tlast))
    else $error("error beat with pixel data or tlast");

  // once halted, nothing reaches the compute stage until a new image
  a_halt_drop: assert property (@(posedge clk) disable iff (rst)
    (halted && !soi) |-> !s1_load)
    else $error("beat loaded while halted");

  // halt is only left through start of image
  a_halt_hold: assert property (@(posedge clk) disable iff (rst)
    (in_fire && halted && !soi) |=> halted)
    else $error("halt released without start of image");

  // waiting for a filter byte means the row position is back at zero
  a_aw_pos: assert property (@(posedge clk) disable iff (rst)
    awaiting |-> (pos == '0))
    else $error("row position nonzero while awaiting filter byte");

endmodule
`default_nettype wire

// ===== rtl/png_unf_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// png_unf_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module png_unf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/png_unf_predict.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// png_unf_predict
// Predictor for the five PNG filter types from left, above and above-left.
// ----------------------------------------------------------------------------
module png_unf_predict (
  input  wire logic [2:0] filter,
  input  wire logic [7:0] a,
  input  wire logic [7:0] b,
  input  wire logic [7:0] c,
  output      logic [7:0] pred
);

  logic signed [10:0] pa, pb, pc;
  logic signed [10:0] da, db, dc;
  logic [8:0]         avg_sum;
  logic [7:0]         paeth;

  // distances to p = a + b - c, written without forming p
  always_comb begin
    pa = 11'(signed'({3'b000, b})) - 11'(signed'({3'b000, c}));
    pb = 11'(signed'({3'b000, a})) - 11'(signed'({3'b000, c}));
    pc = pa + pb;
    da = (pa < 0) ? -pa : pa;
    db = (pb < 0) ? -pb : pb;
    dc = (pc < 0) ? -pc : pc;
    if (da <= db && da <= dc) begin
      paeth = a;
    end else if (db <= dc) begin
      paeth = b;
    end else begin
      paeth = c;
    end
  end

  assign avg_sum = {1'b0, a} + {1'b0, b};

  always_comb begin
    case (filter)
      png_unf_pkg::FILT_SUB:     pred = a;
      png_unf_pkg::FILT_UP:      pred = b;
      png_unf_pkg::FILT_AVERAGE: pred = avg_sum[8:1];
      png_unf_pkg::FILT_PAETH:   pred = paeth;
      default:                   pred = 8'd0;
    endcase
  end

endmodule
`default_nettype wire
